>>> src/rrb_pkg.sv
package rrb_pkg;

   localparam int COORD_BITS = 10;

   // configuration field widths
   localparam int LEFT_BITS   = 10;
   localparam int TOP_BITS    = 10;
   localparam int SIZE_BITS   = 11;
   localparam int RADIUS_BITS = 9;
   localparam int COLOR_BITS  = 16;
   localparam int ALPHA_BITS  = 8;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COLOR_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_LEFT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_TOP      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECT_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CORNER_RADIUS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OVERLAY_COLOR = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLEND_ALPHA   = 3'd6;

   // signed width for the shape bounds, with room for corners pulled below zero
   localparam int WIDEST_COORD = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int CALC_BITS    = WIDEST_COORD + 2;
   localparam int SQ_BITS      = 2 * RADIUS_BITS;

   // rgb565 layout
   localparam int RED_BITS   = 5;
   localparam int GREEN_BITS = 6;
   localparam int BLUE_BITS  = 5;
   localparam int CHAN_BITS  = GREEN_BITS;
   localparam int NUM_CHAN   = 3;
   localparam int PROD_BITS  = CHAN_BITS + ALPHA_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = '1;

   typedef struct packed {
      logic [LEFT_BITS-1:0]   rect_left;
      logic [TOP_BITS-1:0]    rect_top;
      logic [SIZE_BITS-1:0]   rect_width;
      logic [SIZE_BITS-1:0]   rect_height;
      logic [RADIUS_BITS-1:0] corner_radius;
      logic [COLOR_BITS-1:0]  overlay_color;
      logic [ALPHA_BITS-1:0]  blend_alpha;
   } cfg_type;

   // register values after reset: a one by one box at the origin
   localparam cfg_type CFG_RESET = '{
      rect_left:     '0,
      rect_top:      '0,
      rect_width:    SIZE_BITS'(1),
      rect_height:   SIZE_BITS'(1),
      corner_radius: '0,
      overlay_color: '0,
      blend_alpha:   '0
   };

   // exact s / 255 for the sums that a channel blend can reach
   function automatic logic [CHAN_BITS-1:0] div255(input logic [SUM_BITS-1:0] s);
      logic [SUM_BITS-1:0] t;
      t = s + SUM_BITS'(1) + (s >> ALPHA_BITS);
      return t[ALPHA_BITS +: CHAN_BITS];
   endfunction

endpackage

>>> src/rrb_csr.sv
module rrb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [rrb_pkg::CSR_INDEX_BITS-1:0]   wr_index,
   input  logic [rrb_pkg::CSR_DATA_BITS-1:0]    wr_data,
   output rrb_pkg::cfg_type                     cfg
);

   rrb_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rrb_pkg::CFG_RESET;
      end else if (wr_en) begin
         unique case (wr_index)
            rrb_pkg::REG_RECT_LEFT: begin
               cfg_ff.rect_left <= wr_data[rrb_pkg::LEFT_BITS-1:0];
            end
            rrb_pkg::REG_RECT_TOP: begin
               cfg_ff.rect_top <= wr_data[rrb_pkg::TOP_BITS-1:0];
            end
            rrb_pkg::REG_RECT_WIDTH: begin
               cfg_ff.rect_width <= wr_data[rrb_pkg::SIZE_BITS-1:0];
            end
            rrb_pkg::REG_RECT_HEIGHT: begin
               cfg_ff.rect_height <= wr_data[rrb_pkg::SIZE_BITS-1:0];
            end
            rrb_pkg::REG_CORNER_RADIUS: begin
               cfg_ff.corner_radius <= wr_data[rrb_pkg::RADIUS_BITS-1:0];
            end
            rrb_pkg::REG_OVERLAY_COLOR: begin
               cfg_ff.overlay_color <= wr_data[rrb_pkg::COLOR_BITS-1:0];
            end
            rrb_pkg::REG_BLEND_ALPHA: begin
               cfg_ff.blend_alpha <= wr_data[rrb_pkg::ALPHA_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/rrb_shape.sv
module rrb_shape (
   input  logic                              clock,
   input  rrb_pkg::cfg_type                  cfg,
   input  logic [rrb_pkg::COORD_BITS-1:0]    pixel_x,
   input  logic [rrb_pkg::COORD_BITS-1:0]    pixel_y,
   output logic                              covered
);

   localparam int W = rrb_pkg::CALC_BITS;
   localparam int R = rrb_pkg::RADIUS_BITS;
   localparam int S = rrb_pkg::SQ_BITS;

   logic signed [W-1:0] px, py, left, top, right, bottom, rad;
   logic signed [W-1:0] il, ir, it, ib, cx, cy, dx, dy;

   // stage b: bounds and corner offsets
   logic         box_in, band_in;
   logic [R-1:0] adx_in, ady_in;
   logic         box_ff, band_ff;
   logic [R-1:0] adx_ff, ady_ff;

   // stage c: squares
   logic [S-1:0] dx2_ff, dy2_ff, rr_ff;
   logic         box_c_ff, band_c_ff;

   // stage d: decision
   logic         covered_in, covered_ff;

   always_comb begin
      px     = W'(pixel_x);
      py     = W'(pixel_y);
      left   = W'(cfg.rect_left);
      top    = W'(cfg.rect_top);
      rad    = W'(cfg.corner_radius);
      right  = left + W'(cfg.rect_width) - W'(1);
      bottom = top + W'(cfg.rect_height) - W'(1);
      il     = left + rad;
      ir     = right - rad;
      it     = top + rad;
      ib     = bottom - rad;

      box_in  = (px >= left) && (px <= right) && (py >= top) && (py <= bottom);
      band_in = ((px >= il) && (px <= ir)) || ((py >= it) && (py <= ib));

      // nearest inner corner; the offsets stay within the radius whenever used
      cx = (px < il) ? il : ir;
      cy = (py < it) ? it : ib;
      dx = px - cx;
      dy = py - cy;
      adx_in = R'(dx[W-1] ? -dx : dx);
      ady_in = R'(dy[W-1] ? -dy : dy);
   end

   always_ff @(posedge clock) begin
      box_ff  <= box_in;
      band_ff <= band_in;
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
   end

   always_ff @(posedge clock) begin
      dx2_ff    <= S'(adx_ff) * S'(adx_ff);
      dy2_ff    <= S'(ady_ff) * S'(ady_ff);
      rr_ff     <= S'(cfg.corner_radius) * S'(cfg.corner_radius);
      box_c_ff  <= box_ff;
      band_c_ff <= band_ff;
   end

   assign covered_in = box_c_ff &&
                       (band_c_ff || ((S+1)'(dx2_ff) + (S+1)'(dy2_ff) <= (S+1)'(rr_ff)));

   always_ff @(posedge clock) begin
      covered_ff <= covered_in;
   end

   assign covered = covered_ff;

endmodule

>>> src/rrb_blend.sv
module rrb_blend (
   input  logic                              clock,
   input  rrb_pkg::cfg_type                  cfg,
   input  logic [rrb_pkg::COLOR_BITS-1:0]    base_color,
   output logic [rrb_pkg::COLOR_BITS-1:0]    blend_color,
   output logic [rrb_pkg::COLOR_BITS-1:0]    base_delayed
);

   localparam int C = rrb_pkg::CHAN_BITS;
   localparam int P = rrb_pkg::PROD_BITS;
   localparam int N = rrb_pkg::NUM_CHAN;

   logic [C-1:0]                     base_ch [N];
   logic [C-1:0]                     over_ch [N];
   logic [rrb_pkg::ALPHA_BITS-1:0]   inv_alpha;

   logic [P-1:0]                     pb_ff [N];
   logic [P-1:0]                     po_ff [N];
   logic [C-1:0]                     q_in  [N];
   logic [rrb_pkg::COLOR_BITS-1:0]   mix_in;

   logic [rrb_pkg::COLOR_BITS-1:0]   base_b_ff, base_c_ff, base_d_ff;
   logic [rrb_pkg::COLOR_BITS-1:0]   mix_c_ff, mix_d_ff;

   always_comb begin
      base_ch[0] = C'(base_color[15:11]);
      base_ch[1] = base_color[10:5];
      base_ch[2] = C'(base_color[4:0]);
      over_ch[0] = C'(cfg.overlay_color[15:11]);
      over_ch[1] = cfg.overlay_color[10:5];
      over_ch[2] = C'(cfg.overlay_color[4:0]);
      inv_alpha  = rrb_pkg::ALPHA_MAX - cfg.blend_alpha;
   end

   // stage b: channel products
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         pb_ff[i] <= P'(base_ch[i]) * P'(inv_alpha);
         po_ff[i] <= P'(over_ch[i]) * P'(cfg.blend_alpha);
      end
      base_b_ff <= base_color;
   end

   // stage c: sum and divide by 255
   always_comb begin
      for (int i = 0; i < N; i++) begin
         q_in[i] = rrb_pkg::div255(rrb_pkg::SUM_BITS'(pb_ff[i]) +
                                   rrb_pkg::SUM_BITS'(po_ff[i]));
      end
      mix_in = {q_in[0][rrb_pkg::RED_BITS-1:0], q_in[1][rrb_pkg::GREEN_BITS-1:0],
                q_in[2][rrb_pkg::BLUE_BITS-1:0]};
   end

   always_ff @(posedge clock) begin
      mix_c_ff  <= mix_in;
      base_c_ff <= base_b_ff;
   end

   // stage d: line up with the shape decision
   always_ff @(posedge clock) begin
      mix_d_ff  <= mix_c_ff;
      base_d_ff <= base_c_ff;
   end

   assign blend_color  = mix_d_ff;
   assign base_delayed = base_d_ff;

endmodule

>>> src/rounded_rect_rgb565_alpha_blend.sv
// Rounded-rectangle RGB565 compositor. One pixel item is taken in every clock
// cycle while busy is low; busy is high only during reset and the cycle after.
// Each item gives exactly one result, shown for one cycle with rsp_valid;
// results leave in the order items came in and the receiver cannot stall them.
// The pipeline runs through the input register, the bounds, corner offsets and
// channel products, the squares and divide by 255, the radius compare, and the
// output register.
// Registers are to be written through the csr_ port only while no item is in
// flight; the block itself does not enforce this.
module rounded_rect_rgb565_alpha_blend (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rrb_pkg::COORD_BITS-1:0]       req_pixel_x,
   input  logic [rrb_pkg::COORD_BITS-1:0]       req_pixel_y,
   input  logic [rrb_pkg::COLOR_BITS-1:0]       req_base_color,
   output logic                                 rsp_valid,
   output logic [rrb_pkg::COLOR_BITS-1:0]       rsp_out_color,
   output logic                                 rsp_covered,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rrb_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int STAGES = 4;

   rrb_pkg::cfg_type                     cfg;
   logic                                 busy_ff;
   logic [STAGES-1:0]                    vld_ff;
   logic                                 accept;

   logic [rrb_pkg::COORD_BITS-1:0]       px_ff, py_ff;
   logic [rrb_pkg::COLOR_BITS-1:0]       base_ff;

   logic                                 covered;
   logic [rrb_pkg::COLOR_BITS-1:0]       blend_color, base_delayed;

   logic                                 rsp_valid_ff, rsp_covered_ff;
   logic [rrb_pkg::COLOR_BITS-1:0]       rsp_out_color_ff;

   assign accept = start && !busy_ff && !reset;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   rrb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && !busy_ff),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // stage a: input register
   always_ff @(posedge clock) begin
      px_ff   <= req_pixel_x;
      py_ff   <= req_pixel_y;
      base_ff <= req_base_color;
   end

   // valid bits for stages a through d
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-2:0], accept};
      end
   end

   rrb_shape u_shape (
      .clock   (clock),
      .cfg     (cfg),
      .pixel_x (px_ff),
      .pixel_y (py_ff),
      .covered (covered)
   );

   rrb_blend u_blend (
      .clock        (clock),
      .cfg          (cfg),
      .base_color   (base_ff),
      .blend_color  (blend_color),
      .base_delayed (base_delayed)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
      rsp_covered_ff   <= covered;
      rsp_out_color_ff <= covered ? blend_color : base_delayed;
   end

   assign busy          = busy_ff;
   assign csr_ready     = !busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_covered   = rsp_covered_ff;
   assign rsp_out_color = rsp_out_color_ff;

endmodule

>>> src/rrb_checker.sv
module rrb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [rrb_pkg::COLOR_BITS-1:0]       req_base_color,
   input logic                                 rsp_valid,
   input logic [rrb_pkg::COLOR_BITS-1:0]       rsp_out_color,
   input logic                                 rsp_covered
);

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low in the cycle after reset");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted item gave no result");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without an accepted item");

   a_uncovered_passes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_covered) |-> (rsp_out_color == $past(req_base_color, 5)))
      else $error("uncovered pixel color changed");

endmodule

bind rounded_rect_rgb565_alpha_blend rrb_checker u_rrb_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_base_color (req_base_color),
   .rsp_valid      (rsp_valid),
   .rsp_out_color  (rsp_out_color),
   .rsp_covered    (rsp_covered)
);

>>> sim/tb_rounded_rect_rgb565_alpha_blend.sv
`timescale 1ns / 1ps

module tb_rounded_rect_rgb565_alpha_blend;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 11;
   localparam int PIPE_LATENCY = 5;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASES = 8;
   localparam int PHASE_PIXELS = 60;
   localparam logic [rrb_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [rrb_pkg::COLOR_BITS-1:0] color;
      logic                           covered;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [rrb_pkg::COORD_BITS-1:0] req_pixel_x = '0;
   logic [rrb_pkg::COORD_BITS-1:0] req_pixel_y = '0;
   logic [rrb_pkg::COLOR_BITS-1:0] req_base_color = '0;
   logic rsp_valid;
   logic [rrb_pkg::COLOR_BITS-1:0] rsp_out_color;
   logic rsp_covered;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rrb_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rrb_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   rrb_pkg::cfg_type shape_cfg;
   pixel_result_type expected_pixels[$];
   int mismatches = 0;
   int idle_cycles = 0;

   rounded_rect_rgb565_alpha_blend DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_base_color(req_base_color),
      .rsp_valid(rsp_valid),
      .rsp_out_color(rsp_out_color),
      .rsp_covered(rsp_covered),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic int blend_channel(input int base, input int over, input int alpha);
      return (base * (int'(rrb_pkg::ALPHA_MAX) - alpha) + over * alpha)
             / int'(rrb_pkg::ALPHA_MAX);
   endfunction

   function automatic pixel_result_type predict_pixel(
         input logic [rrb_pkg::COORD_BITS-1:0] x,
         input logic [rrb_pkg::COORD_BITS-1:0] y,
         input logic [rrb_pkg::COLOR_BITS-1:0] base);
      int px, py, left, top, r, right, bottom, il, ir, it, ib, dx, dy, a;
      logic [rrb_pkg::COLOR_BITS-1:0] over;
      logic hit;
      pixel_result_type res;
      px = int'(x);
      py = int'(y);
      left = int'(shape_cfg.rect_left);
      top = int'(shape_cfg.rect_top);
      r = int'(shape_cfg.corner_radius);
      right = left + int'(shape_cfg.rect_width) - 1;
      bottom = top + int'(shape_cfg.rect_height) - 1;
      il = left + r;
      ir = right - r;
      it = top + r;
      ib = bottom - r;
      if (px < left || px > right || py < top || py > bottom) begin
         hit = 1'b0;
      end else if ((px >= il && px <= ir) || (py >= it && py <= ib)) begin
         hit = 1'b1;
      end else begin
         // nearest inner corner center
         dx = px - ((px < il) ? il : ir);
         dy = py - ((py < it) ? it : ib);
         hit = (dx * dx + dy * dy <= r * r);
      end
      a = int'(shape_cfg.blend_alpha);
      over = shape_cfg.overlay_color;
      res.covered = hit;
      if (hit) begin
         res.color = {
            rrb_pkg::RED_BITS'(blend_channel(
               int'(base[rrb_pkg::COLOR_BITS-1 -: rrb_pkg::RED_BITS]),
               int'(over[rrb_pkg::COLOR_BITS-1 -: rrb_pkg::RED_BITS]), a)),
            rrb_pkg::GREEN_BITS'(blend_channel(
               int'(base[rrb_pkg::BLUE_BITS +: rrb_pkg::GREEN_BITS]),
               int'(over[rrb_pkg::BLUE_BITS +: rrb_pkg::GREEN_BITS]), a)),
            rrb_pkg::BLUE_BITS'(blend_channel(
               int'(base[rrb_pkg::BLUE_BITS-1:0]),
               int'(over[rrb_pkg::BLUE_BITS-1:0]), a))};
      end else begin
         res.color = base;
      end
      return res;
   endfunction

   function automatic rrb_pkg::cfg_type make_shape(input int left, input int top, input int w,
                                                   input int h, input int r, input int color,
                                                   input int alpha);
      rrb_pkg::cfg_type c;
      c.rect_left = rrb_pkg::LEFT_BITS'(left);
      c.rect_top = rrb_pkg::TOP_BITS'(top);
      c.rect_width = rrb_pkg::SIZE_BITS'(w);
      c.rect_height = rrb_pkg::SIZE_BITS'(h);
      c.corner_radius = rrb_pkg::RADIUS_BITS'(r);
      c.overlay_color = rrb_pkg::COLOR_BITS'(color);
      c.blend_alpha = rrb_pkg::ALPHA_BITS'(alpha);
      return c;
   endfunction

   // random bits above the register width, which the block must drop
   function automatic logic [rrb_pkg::CSR_DATA_BITS-1:0] with_junk(
         input logic [rrb_pkg::CSR_DATA_BITS-1:0] value,
         input int bits, input bit junk);
      logic [rrb_pkg::CSR_DATA_BITS-1:0] keep;
      keep = (rrb_pkg::CSR_DATA_BITS'(1) << bits) - rrb_pkg::CSR_DATA_BITS'(1);
      if (bits >= rrb_pkg::CSR_DATA_BITS)
         keep = '1;
      return junk ? ((value & keep) | (rrb_pkg::CSR_DATA_BITS'($urandom) & ~keep)) : value;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic write_reg(input logic [rrb_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [rrb_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rrb_pkg::REG_RECT_LEFT:
            shape_cfg.rect_left = data[rrb_pkg::LEFT_BITS-1:0];
         rrb_pkg::REG_RECT_TOP:
            shape_cfg.rect_top = data[rrb_pkg::TOP_BITS-1:0];
         rrb_pkg::REG_RECT_WIDTH:
            shape_cfg.rect_width = data[rrb_pkg::SIZE_BITS-1:0];
         rrb_pkg::REG_RECT_HEIGHT:
            shape_cfg.rect_height = data[rrb_pkg::SIZE_BITS-1:0];
         rrb_pkg::REG_CORNER_RADIUS:
            shape_cfg.corner_radius = data[rrb_pkg::RADIUS_BITS-1:0];
         rrb_pkg::REG_OVERLAY_COLOR:
            shape_cfg.overlay_color = data[rrb_pkg::COLOR_BITS-1:0];
         rrb_pkg::REG_BLEND_ALPHA:
            shape_cfg.blend_alpha = data[rrb_pkg::ALPHA_BITS-1:0];
         default: ;
      endcase
   endtask

   // only called with nothing in flight
   task automatic load_shape(input rrb_pkg::cfg_type c, input bit junk);
      write_reg(REG_UNUSED, rrb_pkg::CSR_DATA_BITS'($urandom));
      write_reg(rrb_pkg::REG_RECT_LEFT,
                with_junk(rrb_pkg::CSR_DATA_BITS'(c.rect_left), rrb_pkg::LEFT_BITS, junk));
      write_reg(rrb_pkg::REG_RECT_TOP,
                with_junk(rrb_pkg::CSR_DATA_BITS'(c.rect_top), rrb_pkg::TOP_BITS, junk));
      write_reg(rrb_pkg::REG_RECT_WIDTH,
                with_junk(rrb_pkg::CSR_DATA_BITS'(c.rect_width), rrb_pkg::SIZE_BITS, junk));
      write_reg(rrb_pkg::REG_RECT_HEIGHT,
                with_junk(rrb_pkg::CSR_DATA_BITS'(c.rect_height), rrb_pkg::SIZE_BITS, junk));
      write_reg(rrb_pkg::REG_CORNER_RADIUS,
                with_junk(rrb_pkg::CSR_DATA_BITS'(c.corner_radius), rrb_pkg::RADIUS_BITS,
                          junk));
      write_reg(rrb_pkg::REG_OVERLAY_COLOR, c.overlay_color);
      write_reg(rrb_pkg::REG_BLEND_ALPHA,
                with_junk(rrb_pkg::CSR_DATA_BITS'(c.blend_alpha), rrb_pkg::ALPHA_BITS, junk));
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input int x, input int y, input int color, input int gap);
      start <= 1'b1;
      req_pixel_x <= rrb_pkg::COORD_BITS'(x);
      req_pixel_y <= rrb_pkg::COORD_BITS'(y);
      req_base_color <= rrb_pkg::COLOR_BITS'(color);
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic test_reset_shape();
      send_pixel(0, 0, 16'hFFFF, pick_gap());
      send_pixel(1, 0, 16'h1234, pick_gap());
      send_pixel(0, 1, 16'hA5A5, pick_gap());
      drain();
   endtask

   task automatic test_shape_edges();
      load_shape(make_shape(100, 200, 20, 10, 4, 16'hF81F, 255), 1'b0);
      send_pixel(99, 205, 16'hFFFF, pick_gap());
      send_pixel(100, 205, 16'h0000, pick_gap());
      send_pixel(119, 205, $urandom, pick_gap());
      send_pixel(120, 205, $urandom, pick_gap());
      send_pixel(100, 200, 16'hFFFF, pick_gap());
      send_pixel(101, 202, $urandom, pick_gap());
      send_pixel(119, 209, $urandom, pick_gap());
      send_pixel(104, 200, 16'h0000, pick_gap());
      drain();
      // distance exactly equal to the radius is inside
      load_shape(make_shape(0, 0, 30, 30, 5, 16'h0000, 128), 1'b1);
      send_pixel(2, 1, 16'hFFFF, pick_gap());
      send_pixel(1, 1, 16'hFFFF, pick_gap());
      drain();
   endtask

   task automatic test_large_radius();
      load_shape(make_shape(10, 10, 6, 4, 511, 16'h07E0, 1), 1'b1);
      send_pixel(10, 10, $urandom, pick_gap());
      send_pixel(15, 13, $urandom, pick_gap());
      send_pixel(12, 11, $urandom, pick_gap());
      send_pixel(13, 12, $urandom, pick_gap());
      drain();
   endtask

   task automatic test_degenerate_sizes();
      load_shape(make_shape(50, 50, 0, 5, 0, 16'hFFFF, 255), 1'b0);
      send_pixel(50, 50, $urandom, pick_gap());
      send_pixel(49, 50, $urandom, pick_gap());
      drain();
      load_shape(make_shape(0, 0, 1024, 1024, 0, 16'hFFFF, 255), 1'b0);
      send_pixel(0, 0, 16'h0000, pick_gap());
      send_pixel(1023, 1023, 16'h0000, pick_gap());
      drain();
      load_shape(make_shape(1023, 1023, 2047, 2047, 511, 16'h001F, 200), 1'b1);
      send_pixel(1023, 1023, $urandom, pick_gap());
      send_pixel(0, 0, $urandom, pick_gap());
      drain();
   endtask

   task automatic test_random_shapes();
      rrb_pkg::cfg_type c;
      bit steady;
      int w, h, r, left, top, right, bottom, x, y;
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 11))
            0: w = 0;
            1: w = 1;
            2: w = 1024;
            3: w = 2047;
            4, 5, 6, 7: w = $urandom_range(2, 64);
            default: w = $urandom_range(1, 1024);
         endcase
         case ($urandom_range(0, 11))
            0: h = 0;
            1: h = 1;
            2: h = 1024;
            3: h = 2047;
            4, 5, 6, 7: h = $urandom_range(2, 64);
            default: h = $urandom_range(1, 1024);
         endcase
         case ($urandom_range(0, 7))
            0: r = 0;
            1: r = 511;
            2: r = $urandom_range(0, 511);
            default: r = $urandom_range(0, ((w < h ? w : h) / 2 + 1) % 512);
         endcase
         left = ($urandom_range(0, 5) == 0) ? 1023 * $urandom_range(0, 1)
                                            : $urandom_range(0, 1023);
         top = ($urandom_range(0, 5) == 0) ? 1023 * $urandom_range(0, 1)
                                           : $urandom_range(0, 1023);
         c = make_shape(left, top, w, h, r, $urandom,
                        ($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
                                                    : $urandom_range(0, 255));
         load_shape(c, $urandom_range(0, 3) == 0);
         right = left + w - 1;
         bottom = top + h - 1;
         steady = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            case ($urandom_range(0, 3))
               0: begin
                  x = $urandom;
                  y = $urandom;
               end
               1: begin
                  x = left + $urandom_range(0, (w > 0) ? w - 1 : 0);
                  y = top + $urandom_range(0, (h > 0) ? h - 1 : 0);
               end
               default: begin
                  // around a corner, one pixel beyond the box on each side
                  x = $urandom_range(0, 1) ? left - 1 + $urandom_range(0, r + 1)
                                           : right + 1 - $urandom_range(0, r + 1);
                  y = $urandom_range(0, 1) ? top - 1 + $urandom_range(0, r + 1)
                                           : bottom + 1 - $urandom_range(0, r + 1);
               end
            endcase
            send_pixel(x, y, $urandom, steady ? 0 : pick_gap());
         end
         drain();
      end
   endtask

   always @(posedge clock) begin
      if (start && !busy)
         expected_pixels.push_back(predict_pixel(req_pixel_x, req_pixel_y, req_base_color));
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected pixel: color %h covered %b", rsp_out_color, rsp_covered);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_color !== want.color || rsp_covered !== want.covered) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("pixel mismatch: expected color %h covered %b, got color %h covered %b",
                           want.color, want.covered, rsp_out_color, rsp_covered);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      shape_cfg = make_shape(0, 0, 1, 1, 0, 0, 0);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_shape();
      test_shape_edges();
      test_large_radius();
      test_degenerate_sizes();
      test_random_shapes();
      repeat (PIPE_LATENCY * 2) @(posedge clock);
      mismatches += expected_pixels.size();
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
